// ===== rtl/core/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// Infix to postfix converter package
// Beat types, token and result codes, stack entry kinds and sequencer states.
// ----------------------------------------------------------------------------
package isp_pkg;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  op_code;
		logic [5:0]  func_id;
		logic [63:0] operand_value;
	} req_t;

	typedef struct packed {
		logic [2:0]  out_kind;
		logic [63:0] out_value;
		logic [2:0]  out_op;
		logic [5:0]  out_func;
		logic [1:0]  out_arity;
		logic [3:0]  err_code;
		logic        last;
	} res_t;

	typedef struct packed {
		logic       op_we;
		logic       op_re;
		logic [7:0] op_wdata;
		logic       ar_we;
		logic       ar_re;
		logic [1:0] ar_wdata;
	} stk_ctl_t;

	localparam logic [2:0] TOK_NUMBER = 3'd0;
	localparam logic [2:0] TOK_CONST  = 3'd1;
	localparam logic [2:0] TOK_FUNC   = 3'd2;
	localparam logic [2:0] TOK_OPER   = 3'd3;
	localparam logic [2:0] TOK_LPAREN = 3'd4;
	localparam logic [2:0] TOK_RPAREN = 3'd5;
	localparam logic [2:0] TOK_COMMA  = 3'd6;
	localparam logic [2:0] TOK_END    = 3'd7;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_POW = 3'd5;

	localparam logic [2:0] KND_NUMBER = 3'd0;
	localparam logic [2:0] KND_CONST  = 3'd1;
	localparam logic [2:0] KND_OPER   = 3'd2;
	localparam logic [2:0] KND_FUNC   = 3'd3;
	localparam logic [2:0] KND_NEG    = 3'd4;
	localparam logic [2:0] KND_ERROR  = 3'd5;
	localparam logic [2:0] KND_END    = 3'd6;

	localparam logic [3:0] ERR_ARITY      = 4'd1;
	localparam logic [3:0] ERR_NO_LPAREN  = 4'd2;
	localparam logic [3:0] ERR_EMPTY_PAR  = 4'd3;
	localparam logic [3:0] ERR_UNMATCHED  = 4'd4;
	localparam logic [3:0] ERR_EMPTY_ARG  = 4'd5;
	localparam logic [3:0] ERR_STRAY_COMMA = 4'd6;
	localparam logic [3:0] ERR_UNCLOSED   = 4'd7;
	localparam logic [3:0] ERR_BAD_TOKEN  = 4'd8;
	localparam logic [3:0] ERR_OVERFLOW   = 4'd9;
	localparam logic [3:0] ERR_UNDERFLOW  = 4'd10;

	localparam logic [1:0] EK_OP   = 2'd0;
	localparam logic [1:0] EK_NEG  = 2'd1;
	localparam logic [1:0] EK_LPAR = 2'd2;
	localparam logic [1:0] EK_FUNC = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_OP_RD,
		ST_OP_EV,
		ST_LP_RD,
		ST_LP_EV,
		ST_AR_RD,
		ST_AR_EV,
		ST_CM_RD,
		ST_CM_EV,
		ST_PUSH,
		ST_ERR,
		ST_END,
		ST_DONE
	} st_t;

	typedef enum logic [1:0] {
		MD_FLUSH,
		MD_RPAR,
		MD_COMMA,
		MD_END
	} mode_t;

endpackage

// ===== rtl/core/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// Infix to postfix converter
// A token passes the idle, dispatch and done states, a read and an evaluate
// state per stack read, the push state per operator, negate or parenthesis
// push, a read state per scan that meets an empty stack, and the error and
// end states per error and end beat, plus any output stall, paced by the
// registered stack read data. Results leave through an output register; the
// last leaves as the token finishes. Reset clears state, pointers, flags only.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter import isp_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int TW = $clog2(STACK_DEPTH + 1);
	localparam logic [TW-1:0] FULL = TW'(STACK_DEPTH);

	st_t           state_q, state_d;
	mode_t         mode_q, mode_d;
	req_t          tok_q;
	logic [TW-1:0] op_top_q, op_top_d;
	logic [TW-1:0] ar_top_q, ar_top_d;
	logic          expect_q, expect_d;
	logic          need_lp_q, need_lp_d;
	logic          err_seen_q, err_seen_d;
	logic [3:0]    err_code_q, err_code_d;
	logic [7:0]    push_q, push_d;
	logic [5:0]    func_q, func_d;
	logic          ret_op_q, ret_op_d;
	logic          hold_v_q;
	res_t          hold_q;
	logic          res_valid_q;
	res_t          res_q;

	stk_ctl_t      ctl;
	logic [AW-1:0] op_addr, ar_addr;
	logic [7:0]    op_rdata;
	logic [1:0]    ar_rdata;
	logic [TW-1:0] top_m1, top_m2, ar_m1;
	logic          put_req, blocked, put_go, out_free;
	res_t          put_data;
	logic [1:0]    ek;
	logic [2:0]    tp, inc_p;
	logic          inc_r, pops;

	function automatic logic [2:0] prec_of(logic [7:0] e);
		logic [2:0] p;
		if (e[7:6] == EK_NEG) begin
			p = 3'd5;
		end else if (e[2:0] == OP_POW) begin
			p = 3'd4;
		end else if (e[2:0] >= OP_MUL) begin
			p = 3'd3;
		end else begin
			p = 3'd2;
		end
		return p;
	endfunction

	function automatic res_t entry_res(logic [7:0] e);
		res_t r;
		r = '0;
		if (e[7:6] == EK_NEG) begin
			r.out_kind  = KND_NEG;
			r.out_arity = 2'd1;
		end else begin
			r.out_kind = KND_OPER;
			r.out_op   = e[2:0];
		end
		return r;
	endfunction

	isp_stacks #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stacks (
		.clk      (clk),
		.ctl      (ctl),
		.op_addr  (op_addr),
		.ar_addr  (ar_addr),
		.op_rdata (op_rdata),
		.ar_rdata (ar_rdata)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign out_free  = !res_valid_q || !res_stall;

	assign top_m1 = op_top_q - TW'(1);
	assign top_m2 = op_top_q - TW'(2);
	assign ar_m1  = ar_top_q - TW'(1);
	assign ek     = op_rdata[7:6];
	assign tp     = prec_of(op_rdata);
	assign inc_p  = prec_of({EK_OP, 3'd0, tok_q.op_code});
	assign inc_r  = (tok_q.op_code == OP_POW);
	assign pops   = (ek == EK_OP || ek == EK_NEG) && !(tp < inc_p || (tp == inc_p && inc_r));

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		op_top_d   = op_top_q;
		ar_top_d   = ar_top_q;
		expect_d   = expect_q;
		need_lp_d  = need_lp_q;
		err_seen_d = err_seen_q;
		err_code_d = err_code_q;
		push_d     = push_q;
		func_d     = func_q;
		ret_op_d   = ret_op_q;
		put_req    = 1'b0;
		put_data   = '0;
		ctl        = '0;
		op_addr    = top_m1[AW-1:0];
		ar_addr    = ar_m1[AW-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (err_seen_q) begin
					state_d = (tok_q.req_type == TOK_END) ? ST_END : ST_DONE;
				end else if (need_lp_q && tok_q.req_type != TOK_LPAREN) begin
					err_code_d = ERR_NO_LPAREN;
					state_d    = ST_ERR;
				end else begin
					case (tok_q.req_type) inside
						TOK_NUMBER, TOK_CONST: begin
							put_req            = 1'b1;
							put_data.out_kind  = (tok_q.req_type == TOK_CONST) ?
								KND_CONST : KND_NUMBER;
							put_data.out_value = tok_q.operand_value;
							expect_d           = 1'b0;
							state_d            = ST_DONE;
						end
						TOK_FUNC: begin
							if (op_top_q == FULL || ar_top_q == FULL) begin
								err_code_d = ERR_OVERFLOW;
								state_d    = ST_ERR;
							end else begin
								ctl.op_we    = 1'b1;
								ctl.op_wdata = {EK_FUNC, tok_q.func_id};
								op_addr      = op_top_q[AW-1:0];
								ctl.ar_we    = 1'b1;
								ctl.ar_wdata = 2'd1;
								ar_addr      = ar_top_q[AW-1:0];
								op_top_d     = op_top_q + TW'(1);
								ar_top_d     = ar_top_q + TW'(1);
								need_lp_d    = 1'b1;
								expect_d     = 1'b1;
								state_d      = ST_DONE;
							end
						end
						TOK_OPER: begin
							if (tok_q.op_code > OP_POW) begin
								err_code_d = ERR_BAD_TOKEN;
								state_d    = ST_ERR;
							end else if (expect_q && tok_q.op_code == OP_SUB) begin
								push_d  = {EK_NEG, 6'd0};
								state_d = ST_PUSH;
							end else if (expect_q && tok_q.op_code == OP_ADD) begin
								state_d = ST_DONE;
							end else begin
								push_d   = {EK_OP, 3'd0, tok_q.op_code};
								expect_d = 1'b1;
								mode_d   = MD_FLUSH;
								state_d  = ST_OP_RD;
							end
						end
						TOK_LPAREN: begin
							need_lp_d = 1'b0;
							expect_d  = 1'b1;
							push_d    = {EK_LPAR, 6'd0};
							state_d   = ST_PUSH;
						end
						TOK_RPAREN: begin
							if (expect_q) begin
								err_code_d = ERR_EMPTY_PAR;
								state_d    = ST_ERR;
							end else begin
								mode_d  = MD_RPAR;
								state_d = ST_OP_RD;
							end
						end
						TOK_COMMA: begin
							if (expect_q) begin
								err_code_d = ERR_EMPTY_ARG;
								state_d    = ST_ERR;
							end else begin
								mode_d  = MD_COMMA;
								state_d = ST_OP_RD;
							end
						end
						default: begin
							mode_d  = MD_END;
							state_d = ST_OP_RD;
						end
					endcase
				end
			end
			ST_OP_RD: begin
				if (op_top_q == '0) begin
					unique case (mode_q)
						MD_FLUSH: state_d = ST_PUSH;
						MD_RPAR: begin
							err_code_d = ERR_UNMATCHED;
							state_d    = ST_ERR;
						end
						MD_COMMA: begin
							err_code_d = ERR_STRAY_COMMA;
							state_d    = ST_ERR;
						end
						default: state_d = ST_END;
					endcase
				end else begin
					ctl.op_re = 1'b1;
					state_d   = ST_OP_EV;
				end
			end
			ST_OP_EV: begin
				if (mode_q == MD_FLUSH) begin
					if (pops) begin
						op_top_d = top_m1;
						put_req  = 1'b1;
						put_data = entry_res(op_rdata);
						state_d  = ST_OP_RD;
					end else begin
						state_d = ST_PUSH;
					end
				end else if (ek == EK_LPAR) begin
					if (mode_q == MD_END) begin
						err_code_d = ERR_UNCLOSED;
						state_d    = ST_ERR;
					end else if (mode_q == MD_RPAR) begin
						op_top_d = top_m1;
						expect_d = 1'b0;
						state_d  = ST_LP_RD;
					end else if (op_top_q < TW'(2) || ar_top_q == '0) begin
						err_code_d = ERR_STRAY_COMMA;
						state_d    = ST_ERR;
					end else begin
						state_d = ST_LP_RD;
					end
				end else begin
					op_top_d = top_m1;
					if (ek == EK_FUNC) begin
						func_d   = op_rdata[5:0];
						ret_op_d = 1'b1;
						state_d  = ST_AR_RD;
					end else begin
						put_req  = 1'b1;
						put_data = entry_res(op_rdata);
						state_d  = ST_OP_RD;
					end
				end
			end
			ST_LP_RD: begin
				if (mode_q == MD_COMMA) begin
					ctl.op_re = 1'b1;
					op_addr   = top_m2[AW-1:0];
					state_d   = ST_LP_EV;
				end else if (op_top_q == '0) begin
					state_d = ST_DONE;
				end else begin
					ctl.op_re = 1'b1;
					state_d   = ST_LP_EV;
				end
			end
			ST_LP_EV: begin
				if (mode_q == MD_COMMA) begin
					if (ek != EK_FUNC) begin
						err_code_d = ERR_STRAY_COMMA;
						state_d    = ST_ERR;
					end else begin
						state_d = ST_CM_RD;
					end
				end else if (ek == EK_FUNC) begin
					op_top_d = top_m1;
					func_d   = op_rdata[5:0];
					ret_op_d = 1'b0;
					state_d  = ST_AR_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_AR_RD: begin
				if (ar_top_q == '0) begin
					err_code_d = ERR_UNDERFLOW;
					state_d    = ST_ERR;
				end else begin
					ctl.ar_re = 1'b1;
					state_d   = ST_AR_EV;
				end
			end
			ST_AR_EV: begin
				ar_top_d = ar_m1;
				if (ar_rdata == 2'd0 || ar_rdata == 2'd3) begin
					err_code_d = ERR_ARITY;
					state_d    = ST_ERR;
				end else begin
					put_req            = 1'b1;
					put_data.out_kind  = KND_FUNC;
					put_data.out_func  = func_q;
					put_data.out_arity = ar_rdata;
					state_d            = ret_op_q ? ST_OP_RD : ST_DONE;
				end
			end
			ST_CM_RD: begin
				ctl.ar_re = 1'b1;
				state_d   = ST_CM_EV;
			end
			ST_CM_EV: begin
				if (ar_rdata != 2'd3) begin
					ctl.ar_we    = 1'b1;
					ctl.ar_wdata = ar_rdata + 2'd1;
				end
				expect_d = 1'b1;
				state_d  = ST_DONE;
			end
			ST_PUSH: begin
				if (op_top_q == FULL) begin
					err_code_d = ERR_OVERFLOW;
					state_d    = ST_ERR;
				end else begin
					ctl.op_we    = 1'b1;
					ctl.op_wdata = push_q;
					op_addr      = op_top_q[AW-1:0];
					op_top_d     = op_top_q + TW'(1);
					state_d      = ST_DONE;
				end
			end
			ST_ERR: begin
				put_req           = 1'b1;
				put_data.out_kind = KND_ERROR;
				put_data.err_code = err_code_q;
				err_seen_d        = 1'b1;
				state_d           = (tok_q.req_type == TOK_END) ? ST_END : ST_DONE;
			end
			ST_END: begin
				put_req           = 1'b1;
				put_data.out_kind = KND_END;
				op_top_d          = '0;
				ar_top_d          = '0;
				expect_d          = 1'b1;
				need_lp_d         = 1'b0;
				err_seen_d        = 1'b0;
				state_d           = ST_DONE;
			end
			ST_DONE: begin
				if (!hold_v_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		blocked = put_req && hold_v_q && !out_free;
		if (blocked) begin
			state_d    = state_q;
			mode_d     = mode_q;
			op_top_d   = op_top_q;
			ar_top_d   = ar_top_q;
			expect_d   = expect_q;
			need_lp_d  = need_lp_q;
			err_seen_d = err_seen_q;
			err_code_d = err_code_q;
			push_d     = push_q;
			func_d     = func_q;
			ret_op_d   = ret_op_q;
			ctl        = '0;
		end
	end

	assign put_go = put_req && !blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MD_FLUSH;
			op_top_q    <= '0;
			ar_top_q    <= '0;
			expect_q    <= 1'b1;
			need_lp_q   <= 1'b0;
			err_seen_q  <= 1'b0;
			ret_op_q    <= 1'b0;
			hold_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			op_top_q   <= op_top_d;
			ar_top_q   <= ar_top_d;
			expect_q   <= expect_d;
			need_lp_q  <= need_lp_d;
			err_seen_q <= err_seen_d;
			ret_op_q   <= ret_op_d;
			if (put_go) begin
				hold_v_q <= 1'b1;
			end else if (state_q == ST_DONE && out_free) begin
				hold_v_q <= 1'b0;
			end
			if ((put_go && hold_v_q) || (state_q == ST_DONE && hold_v_q && out_free)) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		err_code_q <= err_code_d;
		push_q     <= push_d;
		func_q     <= func_d;
		if (state_q == ST_IDLE && req_valid) begin
			tok_q <= req;
		end
		if (put_go) begin
			hold_q <= put_data;
		end
		if (put_go && hold_v_q) begin
			res_q <= {hold_q[$bits(res_t)-1:1], 1'b0};
		end else if (state_q == ST_DONE && hold_v_q && out_free) begin
			res_q <= {hold_q[$bits(res_t)-1:1], 1'b1};
		end
	end

endmodule

// ===== rtl/core/isp_stacks.sv =====
// ----------------------------------------------------------------------------
// Operator and arity stack memories
// Two single-port synchronous memories with registered read data.
// ----------------------------------------------------------------------------
module isp_stacks import isp_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  logic          clk,
	input  stk_ctl_t      ctl,
	input  logic [AW-1:0] op_addr,
	input  logic [AW-1:0] ar_addr,
	output logic [7:0]    op_rdata,
	output logic [1:0]    ar_rdata
);

	logic [7:0] op_mem [STACK_DEPTH];
	logic [1:0] ar_mem [STACK_DEPTH];
	logic [7:0] op_rdata_q;
	logic [1:0] ar_rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.op_we) begin
			op_mem[op_addr] <= ctl.op_wdata;
		end
		if (ctl.op_re) begin
			op_rdata_q <= op_mem[op_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ar_we) begin
			ar_mem[ar_addr] <= ctl.ar_wdata;
		end
		if (ctl.ar_re) begin
			ar_rdata_q <= ar_mem[ar_addr];
		end
	end

	assign op_rdata = op_rdata_q;
	assign ar_rdata = ar_rdata_q;

endmodule
